@@ rtl/core/ppmc_pkg.sv @@
`timescale 1ns / 1ps

package ppmc_pkg;

  localparam int SLOTS_DEFAULT  = 7;
  localparam int MOTORS_DEFAULT = 4;

  localparam int SYNC_W = 16;
  localparam int PWM_W  = 17;
  localparam int CAP_W  = 16;
  localparam int CMP_W  = 16;

  localparam logic [SYNC_W-1:0] SYNC_RESET       = 16'd5376;
  localparam logic [PWM_W-1:0]  PWM_PERIOD_RESET = 17'd3200;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 1'b1;

  // shared divider geometry, dividend is 100 times a capture width
  localparam int DIV_W  = 23;
  localparam int DVR_W  = 16;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // reciprocals of 100, exact for 16 and 24 bit operands
  localparam int          RCP16_SH = 23;
  localparam logic [16:0] RCP16    = 17'd83887;
  localparam int          RCP24_SH = 31;
  localparam logic [24:0] RCP24    = 25'd21474837;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/ppm_capture_to_motor_pwm.sv @@
`timescale 1ns / 1ps
// flow: a motor slot passes one division of 23 steps on the shared restoring divider,
//   then the remap, quotient, product and reciprocal steps, and then the output register
// input: in_stall_o holds new slots until the current one is loaded for output; sync,
//   counted and ignored slots are taken in idle, and a zero period goes straight to done
// reset: asynchronous active low; control and config registers return to their reset
//   values and the slot counter waits for sync

module ppm_capture_to_motor_pwm import ppmc_pkg::*; #(
  parameter int SLOTS_PER_FRAME = SLOTS_DEFAULT,
  parameter int MOTOR_OUTPUTS   = MOTORS_DEFAULT,
  localparam int IdxW = (MOTOR_OUTPUTS > 1) ? $clog2(MOTOR_OUTPUTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CAP_W-1:0]      capture_period_i,
  input  logic [CAP_W-1:0]      capture_width_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdxW-1:0]       motor_index_o,
  output logic [CMP_W-1:0]      compare_value_o,
  output logic                  period_error_o
);

  localparam int SlotW = $clog2(SLOTS_PER_FRAME + 1);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOTS_PER_FRAME - 1);
  localparam logic [SlotW-1:0] SlotEnd  = SlotW'(SLOTS_PER_FRAME);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_QUOT  = 3'd3;
  localparam logic [2:0] ST_PROD  = 3'd4;
  localparam logic [2:0] ST_RECIP = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SYNC_W-1:0] sync_q;
  logic [PWM_W-1:0]  pwm_q;
  logic [15:0]       d_q, d_d;
  logic [15:0]       r_q, r_d;
  logic [9:0]        a_q, a_d;
  logic [23:0]       bp_q, bp_d;
  logic [15:0]       ap_q, ap_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CMP_W-1:0]  cmp_q, cmp_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   out_idx_q;
  logic [CMP_W-1:0]  out_cmp_q;
  logic              out_err_q;
  logic              out_load;

  logic [SlotW-1:0]  slot_inc;
  logic [15:0]       x;
  logic [18:0]       x5;
  logic [32:0]       ra;
  logic [15:0]       b_full;
  logic [48:0]       bpm;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  ppmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_inc   = slot_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    d_d      = d_q;
    r_d      = r_q;
    a_d      = a_q;
    bp_d     = bp_q;
    ap_d     = ap_q;
    idx_d    = idx_q;
    cmp_d    = cmp_q;
    err_d    = err_q;
    out_load = 1'b0;
    x        = '0;
    x5       = '0;
    ra       = '0;
    b_full   = '0;
    bpm      = '0;
    div_req  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (capture_width_i > sync_q) begin
            slot_d = '0;
          end else if (slot_q >= SlotLast) begin
            slot_d = SlotEnd;
          end else begin
            slot_d = slot_inc;
            if (32'(slot_inc) <= 32'(MOTOR_OUTPUTS)) begin
              idx_d = IdxW'(slot_q);
              if (capture_period_i == '0) begin
                err_d   = 1'b1;
                cmp_d   = '0;
                state_d = ST_DONE;
              end else begin
                err_d            = 1'b0;
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(capture_width_i) * DIV_W'(100);
                div_req.divisor  = capture_period_i;
                div_req.steps    = STEP_W'(DIV_W);
                state_d          = ST_DIV1;
              end
            end
          end
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          d_d     = div_rsp.quotient[15:0] * 16'd5 - 16'd300;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // 25 * x / 10 is exactly 5 * x / 2
        x       = (d_q > 16'd70) ? d_q - 16'd70 : 16'd70 - d_q;
        x5      = 19'(x) * 19'd5;
        r_d     = (d_q > 16'd70) ? x5[16:1] + 16'd75 : 16'd75 - x5[16:1];
        state_d = ST_QUOT;
      end
      ST_QUOT: begin
        // r split as 100 * a + b
        ra      = 33'(r_q) * 33'(RCP16);
        a_d     = ra[32:RCP16_SH];
        state_d = ST_PROD;
      end
      ST_PROD: begin
        b_full  = r_q - 16'(a_q) * 16'd100;
        bp_d    = 24'(b_full[6:0]) * 24'(pwm_q);
        ap_d    = 16'(a_q) * pwm_q[15:0];
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        bpm     = 49'(bp_q) * 49'(RCP24);
        cmp_d   = ap_q + bpm[RCP24_SH+15:RCP24_SH];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= SlotEnd;
      out_valid_q <= 1'b0;
      sync_q      <= SYNC_RESET;
      pwm_q       <= PWM_PERIOD_RESET;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SYNC_THRESHOLD: sync_q <= cfg_data_i[SYNC_W-1:0];
          CFG_PWM_PERIOD:     pwm_q  <= cfg_data_i[PWM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    r_q   <= r_d;
    a_q   <= a_d;
    bp_q  <= bp_d;
    ap_q  <= ap_d;
    idx_q <= idx_d;
    cmp_q <= cmp_d;
    err_q <= err_d;
    if (out_load) begin
      out_idx_q <= idx_q;
      out_cmp_q <= cmp_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_index_o   = out_idx_q;
  assign compare_value_o = out_cmp_q;
  assign period_error_o  = out_err_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV1))
    else $error("divider finished outside a division step");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished item");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotEnd)
    else $error("slot counter out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_cmp_q == '0))
    else $error("period error with nonzero compare");
`endif

endmodule

@@ rtl/core/ppmc_div.sv @@
`timescale 1ns / 1ps

module ppmc_div import ppmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVR_W-1:0]  rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVR_W-1:0]  dsr_q;

  logic [DVR_W:0]    sh;
  logic [DVR_W:0]    diff;
  logic              ge;

  // one restoring step per cycle, dividend is shifted out of the quotient register from its top bit
  always_comb begin
    sh   = {rem_q, quo_q[DIV_W-1]};
    ge   = sh >= {1'b0, dsr_q};
    diff = sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.steps;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= ge ? diff[DVR_W-1:0] : sh[DVR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
